>>> rtl/ubxp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubxp_pkg: shared types and constants of the binary frame parser
// Sync bytes, register map, result kinds, frame end codes and the
// result record that travels from the parser core to the output register.
// ---------------------------------------------------------------------------
package ubxp_pkg;

   localparam logic [7:0] SyncFirst  = 8'hB5;
   localparam logic [7:0] SyncSecond = 8'h62;

   // Configuration port: one 32-bit register at byte address 0.
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic        RegMaxPayload = 1'b0;   // register index, from paddr[2]
   localparam logic [15:0] MaxPayloadReset = 16'd256;

   localparam logic KindPayload  = 1'b0;
   localparam logic KindFrameEnd = 1'b1;

   localparam logic [1:0] StatusGood     = 2'd0;
   localparam logic [1:0] StatusCheckA   = 2'd1;
   localparam logic [1:0] StatusCheckB   = 2'd2;
   localparam logic [1:0] StatusLenRejct = 2'd3;

   typedef enum logic [8:0] {
      PhSync1   = 9'b0_0000_0001,
      PhSync2   = 9'b0_0000_0010,
      PhClass   = 9'b0_0000_0100,
      PhId      = 9'b0_0000_1000,
      PhLenLo   = 9'b0_0001_0000,
      PhLenHi   = 9'b0_0010_0000,
      PhPayload = 9'b0_0100_0000,
      PhCheckA  = 9'b0_1000_0000,
      PhCheckB  = 9'b1_0000_0000
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_length;
      logic [1:0]  status;
   } result_type;

endpackage

>>> rtl/ubxp_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubxp_csr: configuration register block
// Holds the maximum payload length register behind an APB-style port.
// ---------------------------------------------------------------------------
module ubxp_csr
   import ubxp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output logic [15:0]             max_payload
);

   logic [15:0] max_payload_ff;
   logic [15:0] max_payload_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_payload_in = max_payload_ff;
      if (wr_en && (csr_paddr[2] == RegMaxPayload)) begin
         max_payload_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MaxPayloadReset;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == RegMaxPayload) begin
         csr_prdata = {{(CsrDataWidth-16){1'b0}}, max_payload_ff};
      end
   end

   // The low address bits play no part in decoding.
   logic unused_addr;
   assign unused_addr = ^csr_paddr[1:0];

   assign max_payload = max_payload_ff;

endmodule

>>> rtl/ubxp_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubxp_core: frame parser state machine and Fletcher-8 sums
// Consumes one byte per advance and forms at most one result from it.
// ---------------------------------------------------------------------------
module ubxp_core
   import ubxp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] max_payload,
   output logic        res_valid,
   output result_type  res
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;

   logic [7:0]  acc_a;
   logic [7:0]  acc_b;
   logic [15:0] full_length;
   logic [16:0] count_next;

   assign acc_a       = sum_a_ff + rx_byte;
   assign acc_b       = sum_b_ff + acc_a;
   assign full_length = {rx_byte, length_ff[7:0]};
   assign count_next  = {1'b0, count_ff} + 17'd1;

   always_comb begin
      phase_in  = phase_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      count_in  = count_ff;
      res_valid = 1'b0;
      res.kind           = KindPayload;
      res.data_byte      = 8'd0;
      res.byte_index     = 16'd0;
      res.msg_class      = class_ff;
      res.msg_id         = id_ff;
      res.payload_length = length_ff;
      res.status         = StatusGood;

      case (phase_ff)
         PhSync2: begin
            if (rx_byte == SyncSecond) begin
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
               phase_in = PhClass;
            end else begin
               phase_in = PhSync1;
            end
         end
         PhClass: begin
            class_in = rx_byte;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            phase_in = PhId;
         end
         PhId: begin
            id_in    = rx_byte;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            phase_in = PhLenLo;
         end
         PhLenLo: begin
            length_in = {8'd0, rx_byte};
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
            phase_in  = PhLenHi;
         end
         PhLenHi: begin
            length_in = full_length;
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
            count_in  = 16'd0;
            res.payload_length = full_length;
            if (full_length == 16'd0) begin
               phase_in = PhCheckA;
            end else if (full_length < max_payload) begin
               phase_in = PhPayload;
            end else begin
               phase_in   = PhSync1;
               res_valid  = 1'b1;
               res.kind   = KindFrameEnd;
               res.status = StatusLenRejct;
            end
         end
         PhPayload: begin
            sum_a_in       = acc_a;
            sum_b_in       = acc_b;
            count_in       = count_next[15:0];
            res_valid      = 1'b1;
            res.data_byte  = rx_byte;
            res.byte_index = count_ff;
            if (count_next >= {1'b0, length_ff}) begin
               phase_in = PhCheckA;
            end
         end
         PhCheckA: begin
            if (rx_byte == sum_a_ff) begin
               phase_in = PhCheckB;
            end else begin
               phase_in   = PhSync1;
               res_valid  = 1'b1;
               res.kind   = KindFrameEnd;
               res.status = StatusCheckA;
            end
         end
         PhCheckB: begin
            phase_in   = PhSync1;
            res_valid  = 1'b1;
            res.kind   = KindFrameEnd;
            res.status = (rx_byte == sum_b_ff) ? StatusGood : StatusCheckB;
         end
         default: begin
            phase_in = (rx_byte == SyncFirst) ? PhSync2 : PhSync1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhSync1;
         sum_a_ff  <= 8'd0;
         sum_b_ff  <= 8'd0;
         class_ff  <= 8'd0;
         id_ff     <= 8'd0;
         length_ff <= 16'd0;
         count_ff  <= 16'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   // Every frame end sends the parser back to hunting for the first sync byte.
   a_end_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && (res.kind == KindFrameEnd) |=> phase_ff == PhSync1)
      else $error("frame end did not return to sync hunting");

   // A payload byte always lies inside the declared payload.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && (res.kind == KindPayload) |-> res.byte_index < length_ff)
      else $error("payload index beyond declared length");

   // A good second sync byte starts the check sums afresh.
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      advance && (phase_ff == PhSync2) && (rx_byte == SyncSecond)
      |=> (sum_a_ff == 8'd0) && (sum_b_ff == 8'd0))
      else $error("check sums not cleared at frame start");
`endif

endmodule

>>> rtl/ubxp_out_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubxp_out_reg: result register
// Holds one result until the receiver takes it, and reports when a new
// result may be loaded.
// ---------------------------------------------------------------------------
module ubxp_out_reg
   import ubxp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       load_valid,
   input  result_type load_res,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (free) begin
         valid_in = load && load_valid;
         if (load && load_valid) begin
            res_in = load_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

>>> rtl/ubx_frame_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubx_frame_parser: binary frame parser with Fletcher-8 checking
// Finds sync-framed binary messages in a byte stream and reports each
// payload byte and the outcome of every frame.
// ---------------------------------------------------------------------------
// Usage:
// One received byte is offered per transaction on the req_ channel. Each
// byte is first captured in an input register; when the output register
// can take a result, the parser core updates its state and check sums and,
// where the byte yields one, loads a result into the output register, from
// which the rsp_ channel presents it. The block takes one byte per cycle
// for as long as results are taken as fast as they appear; the single
// parser pass per byte sets that rate.
// Payload bytes come out with their index; every frame that completes or
// is abandoned after its header gives one frame end result with a status.
// When the receiver stalls, the result waits in the output register and
// the byte in the input register waits behind it, so at most one further
// transaction is taken before req_ready drops. No result is ever dropped.
// Reset empties both registers, returns the parser to hunting for the
// first sync byte and sets the maximum payload length register to 256.
// The register may be written over csr_ only while no byte is in flight.
// ---------------------------------------------------------------------------
module ubx_frame_parser
   import ubxp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_kind,
   output logic [7:0]              rsp_data_byte,
   output logic [15:0]             rsp_byte_index,
   output logic [7:0]              rsp_msg_class,
   output logic [7:0]              rsp_msg_id,
   output logic [15:0]             rsp_payload_length,
   output logic [1:0]              rsp_status,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff, s1_byte_in;
   logic        out_free;
   logic        s1_fire;
   logic        req_fire;
   logic [15:0] max_payload;
   logic        core_res_valid;
   result_type  core_res;
   result_type  out_res;

   ubxp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_payload (max_payload)
   );

   // The held byte moves on whenever the output register can take its
   // result; bytes that give no result move on under the same rule.
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_rx_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
   end

   ubxp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_fire),
      .rx_byte     (s1_byte_ff),
      .max_payload (max_payload),
      .res_valid   (core_res_valid),
      .res         (core_res)
   );

   ubxp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_fire),
      .load_valid (core_res_valid),
      .load_res   (core_res),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_res    (out_res)
   );

   assign rsp_kind           = out_res.kind;
   assign rsp_data_byte      = out_res.data_byte;
   assign rsp_byte_index     = out_res.byte_index;
   assign rsp_msg_class      = out_res.msg_class;
   assign rsp_msg_id         = out_res.msg_id;
   assign rsp_payload_length = out_res.payload_length;
   assign rsp_status         = out_res.status;

`ifndef SYNTH
   // A byte held behind a stalled result register must wait unchanged.
   a_held_byte_waits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("held byte lost while output stalled");
`endif

endmodule

>>> test/ubx_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubx_result_checker: prediction and comparison for the frame parser
// Follows every accepted byte and register write, works out the result that
// the parser owes for each byte, and compares the results it presents,
// field by field and in order, against those still awaited.
// ---------------------------------------------------------------------------
module ubx_result_checker
   import ubxp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_kind,
   input  logic [7:0]              rsp_data_byte,
   input  logic [15:0]             rsp_byte_index,
   input  logic [7:0]              rsp_msg_class,
   input  logic [7:0]              rsp_msg_id,
   input  logic [15:0]             rsp_payload_length,
   input  logic [1:0]              rsp_status,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   input  logic                    csr_pready,
   output int unsigned             mismatches,
   output int unsigned             outstanding,
   output int unsigned             payload_results,
   output int unsigned             frame_ends,
   output int unsigned             good_frames
);

   phase_type   parse_phase;
   logic [7:0]  sum_a;
   logic [7:0]  sum_b;
   logic [7:0]  frame_class;
   logic [7:0]  frame_id;
   logic [15:0] frame_len;
   logic [15:0] byte_count;
   logic [15:0] length_limit;

   result_type  awaited_results[$];
   int unsigned mismatch_count;
   int unsigned payload_count;
   int unsigned end_count;
   int unsigned good_count;

   function automatic void fold_in(input logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
   endfunction

   function automatic result_type make_result(input logic k, input logic [7:0] d,
                                              input logic [15:0] idx, input logic [1:0] st);
      return '{kind: k, data_byte: d, byte_index: idx, msg_class: frame_class,
               msg_id: frame_id, payload_length: frame_len, status: st};
   endfunction

   // Moves the parser on by one byte; returns 1 when the byte yields a result.
   function automatic bit advance_parser(input logic [7:0] b, output result_type res);
      bit produced;
      produced = 1'b0;
      res = '0;
      case (parse_phase)
         PhSync2: begin
            if (b == SyncSecond) begin
               sum_a = '0;
               sum_b = '0;
               parse_phase = PhClass;
            end else begin
               parse_phase = PhSync1;
            end
         end
         PhClass: begin
            frame_class = b;
            fold_in(b);
            parse_phase = PhId;
         end
         PhId: begin
            frame_id = b;
            fold_in(b);
            parse_phase = PhLenLo;
         end
         PhLenLo: begin
            frame_len = {8'h00, b};
            fold_in(b);
            parse_phase = PhLenHi;
         end
         PhLenHi: begin
            frame_len = {b, frame_len[7:0]};
            fold_in(b);
            byte_count = '0;
            if (frame_len == 16'd0) begin
               parse_phase = PhCheckA;
            end else if (frame_len < length_limit) begin
               parse_phase = PhPayload;
            end else begin
               parse_phase = PhSync1;
               res = make_result(KindFrameEnd, 8'h00, 16'd0, StatusLenRejct);
               produced = 1'b1;
            end
         end
         PhPayload: begin
            res = make_result(KindPayload, b, byte_count, StatusGood);
            produced = 1'b1;
            fold_in(b);
            byte_count = byte_count + 16'd1;
            if (byte_count >= frame_len) begin
               parse_phase = PhCheckA;
            end
         end
         PhCheckA: begin
            if (b == sum_a) begin
               parse_phase = PhCheckB;
            end else begin
               parse_phase = PhSync1;
               res = make_result(KindFrameEnd, 8'h00, 16'd0, StatusCheckA);
               produced = 1'b1;
            end
         end
         PhCheckB: begin
            parse_phase = PhSync1;
            res = make_result(KindFrameEnd, 8'h00, 16'd0,
                              (b == sum_b) ? StatusGood : StatusCheckB);
            produced = 1'b1;
         end
         default: begin
            if (b == SyncFirst) begin
               parse_phase = PhSync2;
            end else begin
               parse_phase = PhSync1;
            end
         end
      endcase
      return produced;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("kind=%0d data=%02h index=%0d class=%02h id=%02h length=%0d status=%0d",
                       r.kind, r.data_byte, r.byte_index, r.msg_class, r.msg_id,
                       r.payload_length, r.status);
   endfunction

   always @(posedge clock) begin : track
      result_type got;
      result_type want;
      if (reset) begin
         parse_phase = PhSync1;
         sum_a = '0;
         sum_b = '0;
         frame_class = '0;
         frame_id = '0;
         frame_len = '0;
         byte_count = '0;
         length_limit = MaxPayloadReset;
         awaited_results.delete();
         mismatch_count = 0;
         payload_count = 0;
         end_count = 0;
         good_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CsrAddrWidth-1:2] == RegMaxPayload) begin
            length_limit = csr_pwdata[15:0];
         end
         if (rsp_valid && rsp_ready) begin
            got = '{kind: rsp_kind, data_byte: rsp_data_byte, byte_index: rsp_byte_index,
                    msg_class: rsp_msg_class, msg_id: rsp_msg_id,
                    payload_length: rsp_payload_length, status: rsp_status};
            if (got.kind == KindPayload) begin
               payload_count++;
            end else begin
               end_count++;
               if (got.status == StatusGood) begin
                  good_count++;
               end
            end
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result with none awaited: %s", $realtime, describe(got));
               end
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(got));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            if (advance_parser(req_rx_byte, want)) begin
               awaited_results.push_back(want);
            end
         end
      end
      mismatches <= mismatch_count;
      outstanding <= awaited_results.size();
      payload_results <= payload_count;
      frame_ends <= end_count;
      good_frames <= good_count;
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the binary frame parser
// Feeds byte streams of well-formed, damaged and oversized frames mixed
// with line noise through the parser under several maximum payload
// settings, with random gaps on both channels, and reports the outcome
// from the result checker.
// ---------------------------------------------------------------------------
module tb_top;
   import ubxp_pkg::*;

   // Cycles without any transaction before the run is declared hung. The
   // slowest correct stretch is a receiver stall behind a sender gap, so
   // this leaves a wide margin.
   localparam int unsigned QuietLimit = 1000;

   // Register addresses: the maximum payload register at byte address 0,
   // and one address past the end of the map, whose writes must be ignored.
   localparam logic [CsrAddrWidth-1:0] AddrMaxPayload = {RegMaxPayload, 2'b00};
   localparam logic [CsrAddrWidth-1:0] AddrBeyondMap  = 3'd4;

   // Ways in which a generated frame may be damaged.
   typedef enum int unsigned {
      FaultNone,
      FaultCheckA,
      FaultCheckB,
      FaultCut
   } fault_kind_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_rx_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_kind;
   logic [7:0]              rsp_data_byte;
   logic [15:0]             rsp_byte_index;
   logic [7:0]              rsp_msg_class;
   logic [7:0]              rsp_msg_id;
   logic [15:0]             rsp_payload_length;
   logic [1:0]              rsp_status;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned payload_results;
   int unsigned frame_ends;
   int unsigned good_frames;

   // Stimulus bookkeeping: bytes handed over so far, the maximum payload
   // length currently programmed, and whether each side may idle.
   int unsigned items_sent = 0;
   int unsigned current_limit = MaxPayloadReset;
   bit          sender_idles = 1'b0;
   bit          receiver_idles = 1'b0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;

   ubx_frame_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_msg_class      (rsp_msg_class),
      .rsp_msg_id         (rsp_msg_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_status         (rsp_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   ubx_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_msg_class      (rsp_msg_class),
      .rsp_msg_id         (rsp_msg_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_status         (rsp_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .payload_results    (payload_results),
      .frame_ends         (frame_ends),
      .good_frames        (good_frames)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver takes results freely, except that while idling is
   // allowed it now and then refuses them for a random burst.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (receiver_idles && $urandom_range(0, 11) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: any transaction on either channel, or register traffic,
   // counts as progress. A long silence means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one byte and returns at the edge where it is taken. Valid is
   // left high, so a following call in the same step keeps the stream
   // back to back; a sender gap first lowers it.
   task automatic send_byte(input logic [7:0] b);
      if (sender_idles && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Sends a byte that falls under the frame check sums.
   task automatic send_summed(input logic [7:0] b, inout logic [7:0] ca, inout logic [7:0] cb);
      ca = ca + b;
      cb = cb + ca;
      send_byte(b);
   endtask

   // Brings the parser to rest: no byte offered, every awaited result
   // delivered, and then a wait for a byte still inside the block that
   // yields no result, as it passes the input register and the core.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // One write over the configuration port: a setup cycle, an access cycle
   // held until pready, then an idle cycle so that back-to-back writes
   // never drive psel twice in the same step.
   task automatic write_register(input logic [CsrAddrWidth-1:0] addr,
                                 input logic [CsrDataWidth-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[CsrAddrWidth-1:2] == RegMaxPayload) begin
         current_limit = 32'(value[15:0]);
      end
      @(posedge clock);
   endtask

   // Sends a whole frame. A length that the parser will reject is followed
   // by nothing, since the parser goes back to hunting at once. A cut frame
   // stops somewhere in the payload or just before the check bytes. When
   // mid_limit is not negative the register is rewritten between the two
   // length bytes, which is the only point at which the limit matters.
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input fault_kind_type fault,
                             input int mid_limit);
      logic [7:0]  ca;
      logic [7:0]  cb;
      int unsigned keep;
      ca = '0;
      cb = '0;
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      send_summed(cls, ca, cb);
      send_summed(id, ca, cb);
      send_summed(len[7:0], ca, cb);
      if (mid_limit >= 0) begin
         settle();
         write_register(AddrMaxPayload, 32'(mid_limit));
      end
      send_summed(len[15:8], ca, cb);
      if (len != 16'd0 && len >= current_limit) begin
         return;
      end
      if (fault == FaultCut) begin
         keep = (len == 16'd0) ? 0 : $urandom_range(0, len - 1);
      end else begin
         keep = len;
      end
      for (int i = 0; i < keep; i++) begin
         send_summed(8'($urandom_range(0, 255)), ca, cb);
      end
      case (fault)
         FaultCut: begin
         end
         FaultCheckA: begin
            send_byte(ca ^ 8'($urandom_range(1, 255)));
         end
         FaultCheckB: begin
            send_byte(ca);
            send_byte(cb ^ 8'($urandom_range(1, 255)));
         end
         default: begin
            send_byte(ca);
            send_byte(cb);
         end
      endcase
   endtask

   // A payload length that the current limit accepts, at most span.
   function automatic logic [15:0] pick_length(input int unsigned span);
      int unsigned longest;
      longest = (current_limit == 0) ? 0 : current_limit - 1;
      if (longest > span) begin
         longest = span;
      end
      return 16'($urandom_range(0, longest));
   endfunction

   // Random traffic until the byte count reaches goal. Most of it is
   // well-formed frames with random content, so that the payload and check
   // phases are reached often; the rest is damaged frames and noise with
   // many stray first sync bytes, broken sync pairs and refused lengths.
   task automatic random_traffic(input int unsigned goal);
      int unsigned    pick;
      int unsigned    n;
      logic [7:0]     b;
      fault_kind_type fault;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = $urandom_range(0, 99);
            if (n < 80) begin
               fault = FaultNone;
            end else if (n < 88) begin
               fault = FaultCheckA;
            end else if (n < 96) begin
               fault = FaultCheckB;
            end else begin
               fault = FaultCut;
            end
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       pick_length(($urandom_range(0, 7) == 0) ? 64 : 12), fault, -1);
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 6)) begin
               b = ($urandom_range(0, 3) == 0) ? SyncFirst : 8'($urandom_range(0, 255));
               send_byte(b);
            end
         end else if (pick < 90) begin
            // A first sync byte followed by anything but the second one,
            // often by a repeated first sync byte.
            n = $urandom_range(0, 254);
            if (n >= SyncSecond) begin
               n++;
            end
            send_byte(SyncFirst);
            send_byte(($urandom_range(0, 1) == 0) ? SyncFirst : 8'(n));
         end else begin
            n = $urandom_range((current_limit == 0) ? 1 : current_limit, 65535);
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(n),
                       FaultNone, -1);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening with the limit still at its reset value: a
      // repeated first sync byte, a zero-length frame with the extreme
      // byte values in its header, a length of all ones that is refused,
      // and the two kinds of check byte failure.
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      send_byte(SyncFirst);
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      send_frame(8'hFF, 8'h00, 16'd0, FaultNone, -1);
      send_frame(8'h00, 8'hFF, 16'hFFFF, FaultNone, -1);
      send_frame(8'h80, 8'h7F, 16'd1, FaultCheckA, -1);
      send_frame(8'h01, 8'h07, 16'd2, FaultCheckB, -1);
      settle();

      // A write beyond the register map must leave the limit alone; the
      // small limit that follows is the first real setting.
      write_register(AddrBeyondMap, 32'd1);
      write_register(AddrMaxPayload, 32'd8);
      random_traffic(300);
      settle();

      // The lowest limit: only zero-length frames get through. The
      // receiver takes every result here.
      receiver_idles = 1'b0;
      write_register(AddrMaxPayload, 32'd1);
      random_traffic(450);

      // The limit is raised between the two length bytes of a frame that
      // the old limit would have refused.
      send_frame(8'h0A, 8'h55, 16'd5, FaultNone, 65535);

      // The highest limit, without idling on either side: a payload
      // longer than 256 bytes, and a length of all ones that is still
      // refused because it equals the limit.
      sender_idles = 1'b0;
      send_frame(8'h01, 8'h07, 16'd260, FaultNone, -1);
      send_frame(8'hFF, 8'hFF, 16'hFFFF, FaultNone, -1);
      random_traffic(850);
      settle();

      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      write_register(AddrMaxPayload, 32'd20);
      random_traffic(1080);
      settle();

      // The last part runs back to back with the reset value restored.
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      write_register(AddrMaxPayload, 32'(MaxPayloadReset));
      random_traffic(1330);

      // Drain the results still owed, then watch a little longer for any
      // result that should not appear at all.
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes under five payload limits; checked %0d payload byte results",
               items_sent, payload_results);
      $display("and %0d frame ends, %0d of them good, with %0d mismatches.",
               frame_ends, good_frames, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
